/* rtl/core/rrrt_pkg.sv */
// rrrt_pkg: shared types and codes for the response routing request table.
// Holds the event kinds, result actions, the table entry layout and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps

package rrrt_pkg;

  localparam int KIND_W   = 2;
  localparam int ID_W     = 32;
  localparam int UID_W    = 32;
  localparam int FID_W    = 8;
  localparam int SEQ_W    = 4;
  localparam int ACTION_W = 3;
  localparam int SLOT_W   = 3;
  localparam int PURGE_W  = 5;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_REQ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RSP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CONN = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DISC = 2'd3;

  // result actions
  localparam logic [ACTION_W-1:0] ACT_NONE    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_BCAST   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_UNICAST = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_GONE    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REFUSED = 3'd4;

  localparam logic [PURGE_W-1:0] PURGE_MAX = 5'd31;

  typedef struct packed {
    logic [ID_W-1:0]  client;
    logic [UID_W-1:0] uid;
    logic [FID_W-1:0] fid;
    logic [SEQ_W-1:0] seq;
  } req_entry_t;

  // per-cell control: load takes the new value, shift takes the right-hand neighbor
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

/* rtl/core/rrrt_req_cell.sv */
// rrrt_req_cell: one slot of the open request table.
// Holds an entry, shifts from its neighbor or loads a new entry, and compares it.
// Depends on rrrt_pkg.
`timescale 1ns / 1ps

module rrrt_req_cell import rrrt_pkg::*; (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic       valid,
  input  req_entry_t nbr,
  input  req_entry_t new_ent,
  input  req_entry_t key,
  output req_entry_t ent,
  output logic       key_hit,
  output logic       cli_hit
);

  req_entry_t ent_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ent_r <= new_ent;
    end else if (ctl.shift) begin
      ent_r <= nbr;
    end
  end

  assign ent     = ent_r;
  assign key_hit = valid && (ent_r.uid == key.uid) && (ent_r.fid == key.fid) &&
                   (ent_r.seq == key.seq);
  assign cli_hit = valid && (ent_r.client == key.client);

endmodule

/* rtl/core/rrrt_cli_cell.sv */
// rrrt_cli_cell: one slot of the connected client list.
// Holds a client id, shifts from its neighbor or loads a new id, and compares it.
// Depends on rrrt_pkg.
`timescale 1ns / 1ps

module rrrt_cli_cell import rrrt_pkg::*; (
  input  logic            clk,
  input  cell_ctl_t       ctl,
  input  logic            valid,
  input  logic [ID_W-1:0] nbr,
  input  logic [ID_W-1:0] new_id,
  input  logic [ID_W-1:0] key,
  output logic [ID_W-1:0] id,
  output logic            hit
);

  logic [ID_W-1:0] id_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      id_r <= new_id;
    end else if (ctl.shift) begin
      id_r <= nbr;
    end
  end

  assign id  = id_r;
  assign hit = valid && (id_r == key);

endmodule

/* rtl/core/response_routing_request_table.sv */
// Response routing request table: tracks open requests and connected clients and
// decides where each response goes. Both tables are rows of cells that compare
// in parallel and compact by shifting one place toward slot 0. Sequencer steps per
// transaction, from accept to result: a request, a connect, a response without a
// match and a disconnect of an unknown id go EXEC then EMIT; a matched response goes
// EXEC, LOOKUP (remove, then client lookup), EMIT; a disconnect of a connected client
// goes EXEC, then PURGE, which removes the first matching entry each cycle until none
// is left, then EMIT. EMIT loads the result into the output register and holds while
// the previous result is stalled and not taken; the next transaction is accepted
// after that, back in IDLE.
// Depends on rrrt_pkg, rrrt_req_cell and rrrt_cli_cell.
`timescale 1ns / 1ps

module response_routing_request_table import rrrt_pkg::*; #(
  parameter int REQUEST_SLOTS = 16,
  parameter int CLIENT_SLOTS  = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // request / event channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [ID_W-1:0]     in_peer_id,
  input  logic [UID_W-1:0]    in_device_uid,
  input  logic [FID_W-1:0]    in_function_id,
  input  logic [SEQ_W-1:0]    in_sequence_number,
  input  logic                in_wants_response,
  // routing decision channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ACTION_W-1:0] out_action,
  output logic [SLOT_W-1:0]   out_client_slot,
  output logic                out_evicted_oldest,
  output logic [PURGE_W-1:0]  out_purged_count
);

  localparam int RCW = $clog2(REQUEST_SLOTS + 1);
  localparam int CIW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int CCW = $clog2(CLIENT_SLOTS + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_LOOKUP = 3'd2;
  localparam logic [2:0] S_PURGE  = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state_r, state_nxt;

  // captured transaction
  logic [KIND_W-1:0] kind_r;
  logic [ID_W-1:0]   cid_r;
  logic [UID_W-1:0]  uid_r;
  logic [FID_W-1:0]  fid_r;
  logic [SEQ_W-1:0]  seq_r;
  logic              wants_r;

  // result being built
  logic [ACTION_W-1:0] act_r, act_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                evict_r, evict_nxt;
  logic [PURGE_W-1:0]  purged_r, purged_nxt;
  logic [ID_W-1:0]     owner_r, owner_nxt;

  // output register
  logic                out_valid_r;
  logic [ACTION_W-1:0] out_action_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_evict_r;
  logic [PURGE_W-1:0]  out_purged_r;

  logic [RCW-1:0] ent_cnt_r, ent_cnt_nxt;
  logic [CCW-1:0] cli_cnt_r, cli_cnt_nxt;

  // request table row
  req_entry_t              ent     [REQUEST_SLOTS];
  cell_ctl_t               req_ctl [REQUEST_SLOTS];
  logic [REQUEST_SLOTS-1:0] req_valid, key_hit, rcli_hit, req_sel;
  logic [REQUEST_SLOTS-1:0] req_first, req_after;
  logic                     req_any;
  logic [ID_W-1:0]          owner;
  req_entry_t               new_ent, key;

  // client list row
  logic [ID_W-1:0]         cid     [CLIENT_SLOTS];
  cell_ctl_t               cli_ctl [CLIENT_SLOTS];
  logic [CLIENT_SLOTS-1:0] cli_valid, cli_hit, cli_first, cli_after;
  logic                    cli_any;
  logic [CIW-1:0]          cli_idx;
  logic [ID_W-1:0]         cli_key;

  logic in_acc;
  logic ent_full, cli_full;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign ent_full = (ent_cnt_r == RCW'(REQUEST_SLOTS));
  assign cli_full = (cli_cnt_r == CCW'(CLIENT_SLOTS));

  assign new_ent = '{client: cid_r, uid: uid_r, fid: fid_r, seq: seq_r};
  assign key     = new_ent;
  // lookup phase searches for the removed entry's owner, otherwise the event's client
  assign cli_key = (state_r == S_LOOKUP) ? owner_r : cid_r;

  genvar g;
  generate
    for (g = 0; g < REQUEST_SLOTS; g++) begin : g_req
      req_entry_t nbr;
      if (g == REQUEST_SLOTS - 1) begin : g_last
        assign nbr = new_ent;
      end else begin : g_mid
        assign nbr = ent[g+1];
      end
      assign req_valid[g] = (RCW'(g) < ent_cnt_r);
      rrrt_req_cell u_cell (
        .clk     (clk),
        .ctl     (req_ctl[g]),
        .valid   (req_valid[g]),
        .nbr     (nbr),
        .new_ent (new_ent),
        .key     (key),
        .ent     (ent[g]),
        .key_hit (key_hit[g]),
        .cli_hit (rcli_hit[g])
      );
    end

    for (g = 0; g < CLIENT_SLOTS; g++) begin : g_cli
      logic [ID_W-1:0] nbr;
      if (g == CLIENT_SLOTS - 1) begin : g_last
        assign nbr = cid_r;
      end else begin : g_mid
        assign nbr = cid[g+1];
      end
      assign cli_valid[g] = (CCW'(g) < cli_cnt_r);
      rrrt_cli_cell u_cell (
        .clk    (clk),
        .ctl    (cli_ctl[g]),
        .valid  (cli_valid[g]),
        .nbr    (nbr),
        .new_id (cid_r),
        .key    (cli_key),
        .id     (cid[g]),
        .hit    (cli_hit[g])
      );
    end
  endgenerate

  // purge removes by client, a response removes by uid/function/sequence
  assign req_sel = (state_r == S_PURGE) ? rcli_hit : key_hit;

  // first hit and everything from it on (those cells shift down)
  always_comb begin
    logic seen;
    seen  = 1'b0;
    owner = '0;
    for (int k = 0; k < REQUEST_SLOTS; k++) begin
      req_first[k] = req_sel[k] && !seen;
      seen         = seen || req_sel[k];
      req_after[k] = seen;
      if (req_first[k]) begin
        owner = owner | ent[k].client;
      end
    end
    req_any = seen;
  end

  always_comb begin
    logic seen;
    seen    = 1'b0;
    cli_idx = '0;
    for (int k = 0; k < CLIENT_SLOTS; k++) begin
      cli_first[k] = cli_hit[k] && !seen;
      seen         = seen || cli_hit[k];
      cli_after[k] = seen;
      if (cli_first[k]) begin
        cli_idx = cli_idx | CIW'(k);
      end
    end
    cli_any = seen;
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    slot_nxt    = slot_r;
    evict_nxt   = evict_r;
    purged_nxt  = purged_r;
    owner_nxt   = owner_r;
    ent_cnt_nxt = ent_cnt_r;
    cli_cnt_nxt = cli_cnt_r;
    for (int k = 0; k < REQUEST_SLOTS; k++) begin
      req_ctl[k] = '0;
    end
    for (int k = 0; k < CLIENT_SLOTS; k++) begin
      cli_ctl[k] = '0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt  = S_EXEC;
          act_nxt    = ACT_NONE;
          slot_nxt   = '0;
          evict_nxt  = 1'b0;
          purged_nxt = '0;
        end
      end

      S_EXEC: begin
        state_nxt = S_EMIT;
        unique case (kind_r)
          KIND_REQ: begin
            if ((uid_r != '0) && wants_r) begin
              if (ent_full) begin
                // drop the oldest: whole row shifts, new entry lands at the tail
                evict_nxt = 1'b1;
                for (int k = 0; k < REQUEST_SLOTS; k++) begin
                  req_ctl[k].shift = 1'b1;
                end
                req_ctl[REQUEST_SLOTS-1].load = 1'b1;
              end else begin
                for (int k = 0; k < REQUEST_SLOTS; k++) begin
                  req_ctl[k].load = (RCW'(k) == ent_cnt_r);
                end
                ent_cnt_nxt = ent_cnt_r + 1'b1;
              end
            end
          end

          KIND_RSP: begin
            act_nxt = ACT_BCAST;
            if ((seq_r != '0) && req_any) begin
              for (int k = 0; k < REQUEST_SLOTS; k++) begin
                req_ctl[k].shift = req_after[k];
              end
              ent_cnt_nxt = ent_cnt_r - 1'b1;
              owner_nxt   = owner;
              state_nxt   = S_LOOKUP;
            end
          end

          KIND_CONN: begin
            if (cli_full) begin
              act_nxt = ACT_REFUSED;
            end else begin
              for (int k = 0; k < CLIENT_SLOTS; k++) begin
                cli_ctl[k].load = (CCW'(k) == cli_cnt_r);
              end
              slot_nxt    = SLOT_W'(cli_cnt_r);
              cli_cnt_nxt = cli_cnt_r + 1'b1;
            end
          end

          KIND_DISC: begin
            if (cli_any) begin
              for (int k = 0; k < CLIENT_SLOTS; k++) begin
                cli_ctl[k].shift = cli_after[k];
              end
              slot_nxt    = SLOT_W'(cli_idx);
              cli_cnt_nxt = cli_cnt_r - 1'b1;
              state_nxt   = S_PURGE;
            end
          end
        endcase
      end

      S_LOOKUP: begin
        if (cli_any) begin
          act_nxt  = ACT_UNICAST;
          slot_nxt = SLOT_W'(cli_idx);
        end else begin
          act_nxt  = ACT_GONE;
          slot_nxt = '0;
        end
        state_nxt = S_EMIT;
      end

      S_PURGE: begin
        // one open request of the departed client per cycle
        if (req_any) begin
          for (int k = 0; k < REQUEST_SLOTS; k++) begin
            req_ctl[k].shift = req_after[k];
          end
          ent_cnt_nxt = ent_cnt_r - 1'b1;
          if (purged_r != PURGE_MAX) begin
            purged_nxt = purged_r + 1'b1;
          end
        end else begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ent_cnt_r   <= '0;
      cli_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ent_cnt_r <= ent_cnt_nxt;
      cli_cnt_r <= cli_cnt_nxt;
      if ((state_r == S_EMIT) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    slot_r   <= slot_nxt;
    evict_r  <= evict_nxt;
    purged_r <= purged_nxt;
    owner_r  <= owner_nxt;
    if (in_acc) begin
      kind_r  <= in_kind;
      cid_r   <= in_peer_id;
      uid_r   <= in_device_uid;
      fid_r   <= in_function_id;
      seq_r   <= in_sequence_number;
      wants_r <= in_wants_response;
    end
    if ((state_r == S_EMIT) && (!out_valid_r || out_ready)) begin
      out_action_r <= act_r;
      out_slot_r   <= slot_r;
      out_evict_r  <= evict_r;
      out_purged_r <= purged_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = out_action_r;
  assign out_client_slot    = out_slot_r;
  assign out_evicted_oldest = out_evict_r;
  assign out_purged_count   = out_purged_r;

`ifndef SYNTHESIS
  a_ent_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ent_cnt_r <= RCW'(REQUEST_SLOTS))
    else $error("request table count above capacity");

  a_cli_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cli_cnt_r <= CCW'(CLIENT_SLOTS))
    else $error("client list count above capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_EXEC))
    else $error("accepted transaction not executed next cycle");

  a_purge_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PURGE) && req_any |=> ent_cnt_r == RCW'($past(ent_cnt_r) - 1'b1))
    else $error("purge hit did not remove an entry");

  a_refuse_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && (kind_r == KIND_CONN) && cli_full |=> cli_cnt_r == $past(cli_cnt_r))
    else $error("refused connect changed the client list");
`endif

endmodule

/* tb/response_routing_request_table_tb.sv */
// Self-checking testbench for response_routing_request_table: random-stall handshakes on both
// channels, a scoreboard class that tracks open requests and connected clients, field-level checks.
// Depends on rrrt_pkg and the response_routing_request_table RTL.
`timescale 1ns / 1ps

module response_routing_request_table_tb;
  import rrrt_pkg::*;

  localparam int REQUEST_SLOTS  = 16;
  localparam int CLIENT_SLOTS   = 8;
  localparam int STIM_ITEMS     = 850;
  // Worst quiet stretch: the longest sender gap, the longest receiver stall and a purge of a full table.
  // Several times over that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_PRINTED    = 40;

  // One input transaction, field order matches the port concatenation in the monitor.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   peer_id;
    logic [UID_W-1:0]  device_uid;
    logic [FID_W-1:0]  function_id;
    logic [SEQ_W-1:0]  seq;
    logic              wants;
  } txn_t;

  // One routing decision.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic                evicted;
    logic [PURGE_W-1:0]  purged;
  } route_t;

  // Scoreboard: mirrors the open-request table and the client list, queues the
  // expected routing decision per accepted transaction and checks results in order.
  class route_scoreboard;
    logic [ID_W-1:0]  open_client [REQUEST_SLOTS];
    logic [UID_W-1:0] open_uid    [REQUEST_SLOTS];
    logic [FID_W-1:0] open_fid    [REQUEST_SLOTS];
    logic [SEQ_W-1:0] open_seq    [REQUEST_SLOTS];
    int               open_count;
    logic [ID_W-1:0]  conn_id     [CLIENT_SLOTS];
    int               conn_count;
    route_t           pending_routes[$];
    int               errors;
    int               results_seen;

    function new();
      open_count   = 0;
      conn_count   = 0;
      errors       = 0;
      results_seen = 0;
    endfunction

    // Remove one open request and close the gap toward slot 0.
    function void remove_open(int at);
      int k;
      for (k = at; k + 1 < open_count; k++) begin
        open_client[k] = open_client[k+1];
        open_uid[k]    = open_uid[k+1];
        open_fid[k]    = open_fid[k+1];
        open_seq[k]    = open_seq[k+1];
      end
      open_count--;
    endfunction

    // First slot holding the id, or -1.
    function int find_client(logic [ID_W-1:0] id);
      int k;
      for (k = 0; k < conn_count; k++)
        if (conn_id[k] == id) return k;
      return -1;
    endfunction

    function void note_input(txn_t t);
      route_t           r;
      int               k;
      int               slot;
      logic [ID_W-1:0]  owner;
      r = '0;
      case (t.kind)
        KIND_REQ: begin
          if (t.device_uid != '0 && t.wants) begin
            if (open_count >= REQUEST_SLOTS) begin
              remove_open(0);
              r.evicted = 1'b1;
            end
            open_client[open_count] = t.peer_id;
            open_uid[open_count]    = t.device_uid;
            open_fid[open_count]    = t.function_id;
            open_seq[open_count]    = t.seq;
            open_count++;
          end
        end
        KIND_RSP: begin
          r.action = ACT_BCAST;
          if (t.seq != '0) begin
            k = 0;
            while (k < open_count && !(open_uid[k] == t.device_uid &&
                   open_fid[k] == t.function_id && open_seq[k] == t.seq))
              k++;
            if (k < open_count) begin
              owner = open_client[k];
              remove_open(k);
              slot = find_client(owner);
              if (slot >= 0) begin
                r.action = ACT_UNICAST;
                r.slot   = slot[SLOT_W-1:0];
              end else begin
                r.action = ACT_GONE;
              end
            end
          end
        end
        KIND_CONN: begin
          if (conn_count >= CLIENT_SLOTS) begin
            r.action = ACT_REFUSED;
          end else begin
            r.slot = conn_count[SLOT_W-1:0];
            conn_id[conn_count] = t.peer_id;
            conn_count++;
          end
        end
        default: begin
          slot = find_client(t.peer_id);
          if (slot >= 0) begin
            r.slot = slot[SLOT_W-1:0];
            k = 0;
            while (k < open_count) begin
              if (open_client[k] == t.peer_id) begin
                remove_open(k);
                if (r.purged != PURGE_MAX) r.purged = r.purged + 1'b1;
              end else begin
                k++;
              end
            end
            for (k = slot; k + 1 < conn_count; k++) conn_id[k] = conn_id[k+1];
            conn_count--;
          end
        end
      endcase
      pending_routes.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task check_result(route_t got);
      route_t want;
      results_seen++;
      if (pending_routes.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding (action %0d)",
                         results_seen, got.action));
      end else begin
        want = pending_routes.pop_front();
        if (got.action !== want.action)
          report($sformatf("result %0d action: got %0d, expected %0d",
                           results_seen, got.action, want.action));
        if (got.slot !== want.slot)
          report($sformatf("result %0d client_slot: got %0d, expected %0d",
                           results_seen, got.slot, want.slot));
        if (got.evicted !== want.evicted)
          report($sformatf("result %0d evicted_oldest: got %0b, expected %0b",
                           results_seen, got.evicted, want.evicted));
        if (got.purged !== want.purged)
          report($sformatf("result %0d purged_count: got %0d, expected %0d",
                           results_seen, got.purged, want.purged));
      end
    endtask

    function int outstanding();
      return pending_routes.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind;
  logic [ID_W-1:0]     in_peer_id;
  logic [UID_W-1:0]    in_device_uid;
  logic [FID_W-1:0]    in_function_id;
  logic [SEQ_W-1:0]    in_sequence_number;
  logic                in_wants_response;
  logic                out_valid;
  logic                out_ready;
  logic [ACTION_W-1:0] out_action;
  logic [SLOT_W-1:0]   out_client_slot;
  logic                out_evicted_oldest;
  logic [PURGE_W-1:0]  out_purged_count;

  route_scoreboard sb;

  // Client ids reused often so connects, duplicates and purges hit each other;
  // all-zeros and all-ones are in the pool on purpose.
  logic [ID_W-1:0]  id_pool  [6];
  // A few shared uids so responses can match entries from several clients.
  logic [UID_W-1:0] uid_pool [4];
  int               conn_weight;   // share of connects among connect/disconnect
  bit               no_gaps;       // stretch with the sender never idling
  int               idle_cycles;

  response_routing_request_table #(
    .REQUEST_SLOTS(REQUEST_SLOTS),
    .CLIENT_SLOTS (CLIENT_SLOTS)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_peer_id        (in_peer_id),
    .in_device_uid     (in_device_uid),
    .in_function_id    (in_function_id),
    .in_sequence_number(in_sequence_number),
    .in_wants_response (in_wants_response),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_action        (out_action),
    .out_client_slot   (out_client_slot),
    .out_evicted_oldest(out_evicted_oldest),
    .out_purged_count  (out_purged_count)
  );

  always #5 clk = ~clk;

  // Monitor. Runs in the active region of the edge, so it sees pre-edge values
  // of every handshake signal. The result side is checked before the new
  // transaction is noted; a result at this edge always belongs to an older one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result(route_t'({out_action, out_client_slot, out_evicted_oldest,
                                  out_purged_count}));
      if (in_valid && in_ready)
        sb.note_input(txn_t'({in_kind, in_peer_id, in_device_uid, in_function_id,
                              in_sequence_number, in_wants_response}));
    end
  end

  // Watchdog: ends the run if neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Mostly short idles, sometimes medium, rarely long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Receiver backpressure: open stretches mixed with random stalls.
  initial begin
    int hold;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) < 3) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        hold = gap_len();
        if (hold > 0) begin
          out_ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  function automatic txn_t mk(logic [KIND_W-1:0] kind, logic [ID_W-1:0] cid,
                              logic [UID_W-1:0] uid, logic [FID_W-1:0] fid,
                              logic [SEQ_W-1:0] seq, logic wants);
    txn_t t;
    t.kind        = kind;
    t.peer_id     = cid;
    t.device_uid  = uid;
    t.function_id = fid;
    t.seq         = seq;
    t.wants       = wants;
    return t;
  endfunction

  function automatic logic [ID_W-1:0] pick_client();
    if ($urandom_range(0, 3) != 0) return id_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  // Random transaction shaped by the current mirror state: most responses hit
  // an open request, most disconnects hit a connected client.
  function automatic txn_t random_txn();
    txn_t t;
    int   r;
    int   k;
    t = mk(KIND_REQ, pick_client(), $urandom, FID_W'($urandom_range(0, 255)),
           SEQ_W'($urandom_range(0, 15)), 1'b1);
    r = $urandom_range(0, 99);
    if (r < 40) begin
      // request; shared keys give duplicate entries across clients
      if ($urandom_range(0, 3) == 0) begin
        t.device_uid  = uid_pool[$urandom_range(0, 3)];
        t.function_id = FID_W'($urandom_range(0, 3));
        t.seq         = SEQ_W'($urandom_range(1, 3));
      end
      if ($urandom_range(0, 19) == 0) t.device_uid = '0;
      if ($urandom_range(0, 9) == 0) t.wants = 1'b0;
    end else if (r < 70) begin
      t.kind  = KIND_RSP;
      t.wants = 1'($urandom_range(0, 1));
      k = $urandom_range(0, 9);
      if (k < 7 && sb.open_count > 0) begin
        k = $urandom_range(0, sb.open_count - 1);
        t.device_uid  = sb.open_uid[k];
        t.function_id = sb.open_fid[k];
        t.seq         = sb.open_seq[k];
      end else if (k < 8) begin
        t.seq = '0;   // unsolicited, always broadcast
      end
    end else if (r < 70 + conn_weight) begin
      t.kind  = KIND_CONN;
      t.wants = 1'($urandom_range(0, 1));
    end else begin
      t.kind  = KIND_DISC;
      t.wants = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 7 && sb.conn_count > 0)
        t.peer_id = sb.conn_id[$urandom_range(0, sb.conn_count - 1)];
    end
    return t;
  endfunction

  // Present one transaction and hold it until the block takes it. Entered and
  // left on a rising edge; the accept edge is where the caller may lower valid.
  task automatic send_txn(input txn_t t);
    in_valid           <= 1'b1;
    in_kind            <= t.kind;
    in_peer_id         <= t.peer_id;
    in_device_uid      <= t.device_uid;
    in_function_id     <= t.function_id;
    in_sequence_number <= t.seq;
    in_wants_response  <= t.wants;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic issue(input txn_t t);
    int gap;
    send_txn(t);
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    txn_t            t;
    int              sent;
    int              iter;
    int              n;
    logic [ID_W-1:0] ca;
    logic [ID_W-1:0] cb;
    logic [ID_W-1:0] fcid;

    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_kind            = KIND_REQ;
    in_peer_id         = '0;
    in_device_uid      = '0;
    in_function_id     = '0;
    in_sequence_number = '0;
    in_wants_response  = 1'b0;
    conn_weight        = 15;
    no_gaps            = 1'b0;
    sb = new();

    id_pool[0] = '0;
    id_pool[1] = '1;
    for (n = 2; n < 6; n++) id_pool[n] = $urandom;
    for (n = 0; n < 4; n++) uid_pool[n] = $urandom | 32'd1;
    ca = 32'h0000_00A5;
    cb = 32'h5A00_0000;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // requests that are not recorded: uid zero, then no response wanted
    issue(mk(KIND_REQ, '0, '0, '0, '0, 1'b1));
    issue(mk(KIND_REQ, '1, 32'h1234_5678, 8'h5A, 4'd3, 1'b0));
    // connect, duplicate connect of the same id, second client
    issue(mk(KIND_CONN, ca, '0, '0, '0, 1'b0));
    issue(mk(KIND_CONN, ca, '0, '0, '0, 1'b0));
    issue(mk(KIND_CONN, cb, '0, '0, '0, 1'b0));
    // field extremes on a recorded request, and an entry with sequence zero
    issue(mk(KIND_REQ, ca, '1, 8'hFF, 4'hF, 1'b1));
    issue(mk(KIND_REQ, ca, 32'd1, 8'h00, 4'h0, 1'b1));
    // unsolicited response: broadcast even though an entry carries seq zero
    issue(mk(KIND_RSP, '0, 32'd1, 8'h00, 4'h0, 1'b0));
    // no match on sequence number, then the match -> first slot of the id
    issue(mk(KIND_RSP, '0, '1, 8'hFF, 4'hE, 1'b1));
    issue(mk(KIND_RSP, '1, '1, 8'hFF, 4'hF, 1'b0));
    // request from a client that never connected, answered -> dropped
    issue(mk(KIND_REQ, 32'h8000_0000, 32'h8000_0000, 8'h80, 4'h8, 1'b1));
    issue(mk(KIND_RSP, '0, 32'h8000_0000, 8'h80, 4'h8, 1'b1));
    // two identical entries for the second client, one answered
    issue(mk(KIND_REQ, cb, 32'd7, 8'h01, 4'h1, 1'b1));
    issue(mk(KIND_REQ, cb, 32'd7, 8'h01, 4'h1, 1'b1));
    issue(mk(KIND_RSP, '0, 32'd7, 8'h01, 4'h1, 1'b0));
    // disconnect of an unknown id is ignored
    issue(mk(KIND_DISC, 32'hDEAD_BEEF, '0, '0, '0, 1'b0));
    // disconnects: purge, list compaction, then the duplicate slot
    issue(mk(KIND_DISC, ca, '0, '0, '0, 1'b0));
    issue(mk(KIND_DISC, cb, '0, '0, '0, 1'b0));
    issue(mk(KIND_DISC, ca, '0, '0, '0, 1'b0));
    // fill the client list, then one connect too many
    for (n = 0; n < CLIENT_SLOTS; n++)
      issue(mk(KIND_CONN, (n < 6) ? id_pool[n] : $urandom, '0, '0, '0, 1'b0));
    issue(mk(KIND_CONN, 32'h0F0F_0F0F, '0, '0, '0, 1'b0));

    // ---- random part ----
    // Phases every 64 iterations shift the connect/disconnect mix so the
    // client list swings between empty and full; some phases run gap-free.
    // Floods connect one client, overfill the table from it (evictions),
    // then disconnect it to purge up to a full table.
    sent = 0;
    iter = 0;
    while (sent < STIM_ITEMS) begin
      if (iter % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       conn_weight = 4;
          1:       conn_weight = 15;
          default: conn_weight = 26;
        endcase
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      iter++;
      if ($urandom_range(0, 39) == 0) begin
        fcid = pick_client();
        n    = $urandom_range(6, 20);
        issue(mk(KIND_CONN, fcid, '0, '0, '0, 1'b0));
        repeat (n)
          issue(mk(KIND_REQ, fcid, $urandom | 32'd1, FID_W'($urandom_range(0, 255)),
                   SEQ_W'($urandom_range(0, 15)), 1'b1));
        issue(mk(KIND_DISC, fcid, '0, '0, '0, 1'b0));
        sent += n + 2;
      end else begin
        t = random_txn();
        issue(t);
        sent++;
      end
    end

    // ---- drain ----
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
